/* src/qau_pkg.sv */
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, action codes and helpers for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_CNJ = 3'd2,
    ACT_SCL = 3'd3,
    ACT_MUL = 3'd4,
    ACT_NRM = 3'd5,
    ACT_INV = 3'd6
  } act_e;

  // sign of each hamilton product term, bit index is lane * 4 + term
  localparam logic [15:0] MUL_NEG = 16'h428E;

  typedef struct packed {
    logic        [2:0]  action;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r_w;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic               saturated;
    logic               divide_by_zero;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               neg;
  } term_t;

  typedef term_t [3:0] term_arr_t;

  // divider status toward the output stage
  typedef struct packed {
    logic       done;
    logic [3:0] sat;
  } div_stat_t;

  // clamp to the signed 32-bit range, msb of the result is the clamp flag
  function automatic logic [32:0] sat32(input logic signed [67:0] v);
    logic [32:0] r;
    if (v > 68'sh0_0000_0000_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -68'sh0_0000_0000_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // operand pairs that lane k multiplies for a given action
  function automatic term_arr_t lane_terms(input logic [2:0] act, input in_t it,
                                           input logic [1:0] k);
    term_arr_t        t;
    logic [3:0][31:0] av;
    logic [3:0][31:0] bv;
    t  = '0;
    av = {it.a_z, it.a_y, it.a_x, it.a_w};
    bv = {it.b_z, it.b_y, it.b_x, it.b_w};
    case (act)
      ACT_MUL: begin
        for (int j = 0; j < 4; j++) begin
          t[j].x   = av[j];
          t[j].y   = bv[k ^ 2'(j)];
          t[j].neg = MUL_NEG[{k, 2'(j)}];
        end
      end
      ACT_SCL: begin
        t[0].x = av[k];
        t[0].y = it.scale_factor;
      end
      ACT_NRM, ACT_INV: begin
        if (k == 2'd0) begin
          for (int j = 0; j < 4; j++) begin
            t[j].x = av[j];
            t[j].y = av[j];
          end
        end
      end
      default: ;
    endcase
    return t;
  endfunction

endpackage

/* src/quaternion_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Fixed point quaternion ALU: add, sub, conjugate, scale, product, norm, inverse.
// ----------------------------------------------------------------------------
// usage:
//   input: drive in_item and raise start; the transfer happens on a rising
//   edge where start is high and busy is low.
//   output: out_valid pulses for one cycle with out_item; the receiver must
//   take it then, it cannot stall the unit.
// pipeline: for every action but inverse, four lanes form the partial
//   products in one registered stage, the merge stage sums, clamps and
//   registers the result.
// throughput: one item per cycle for all actions except inverse, while busy is low.
// inverse: the norm is formed in lane 0, then four restoring dividers run
//   in parallel at one quotient bit a cycle; busy is high from the cycle
//   after the inverse transfer until its result shows. a zero norm skips
//   the dividers and returns zeros with divide_by_zero.
// reset: synchronous, active low; clears the pipeline valids and dividers.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  localparam int DW = 65 - FRAC_BITS;

  logic        accept;
  logic        s1_vld_r;
  in_t         s1_item_r;
  logic        div_act_r, div_act_nxt;
  logic signed [66-FRAC_BITS:0] lane_sum [4];
  logic [DW-1:0] norm;
  logic        n_zero;
  logic        launch;
  logic        s1_inv;
  logic [3:0][31:0] av;
  logic [3:0][31:0] dres;
  logic [3:0]  dsat;
  logic [3:0]  ddone;
  div_stat_t   dstat;

  assign s1_inv = s1_vld_r && (s1_item_r.action == ACT_INV);
  assign busy   = div_act_r || s1_inv;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) s1_item_r <= in_item;
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    qau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .load    (accept),
      .terms   (lane_terms(in_item.action, in_item, 2'(k))),
      .sum_shr (lane_sum[k])
    );
  end

  assign norm   = lane_sum[0][DW-1:0];
  assign n_zero = (norm == '0);
  assign launch = s1_inv && !n_zero;
  assign av     = {s1_item_r.a_z, s1_item_r.a_y, s1_item_r.a_x, s1_item_r.a_w};

  for (genvar k = 0; k < 4; k++) begin : g_div
    logic [31:0] mag;
    logic        neg;
    assign mag = av[k][31] ? (32'd0 - av[k]) : av[k];
    // scalar keeps its sign, vector parts are negated
    assign neg = (k == 0) ? av[k][31] : (!av[k][31] && (av[k] != 32'd0));
    qau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (launch),
      .num_mag ({mag, {FRAC_BITS{1'b0}}}),
      .neg     (neg),
      .den     (norm),
      .done    (ddone[k]),
      .result  (dres[k]),
      .sat     (dsat[k])
    );
  end

  assign dstat = '{done: ddone[0], sat: dsat};

  always_comb begin
    div_act_nxt = div_act_r;
    if (launch)         div_act_nxt = 1'b1;
    else if (ddone[0])  div_act_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) div_act_r <= 1'b0;
    else        div_act_r <= div_act_nxt;
  end

  qau_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld       (s1_vld_r),
    .item      (s1_item_r),
    .lane_sum  (lane_sum),
    .n_zero    (n_zero),
    .dstat     (dstat),
    .dres      (dres),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    ddone[0] |-> !s1_vld_r)
    else $error("divider result collides with a pipeline item");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.divide_by_zero) |->
      (!out_item.saturated && out_item.r_w == 32'd0 && out_item.r_x == 32'd0 &&
       out_item.r_y == 32'd0 && out_item.r_z == 32'd0))
    else $error("divide by zero result not cleared");

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_act_r |-> !accept)
    else $error("item taken while dividers run");
`endif

endmodule

/* src/qau_lane.sv */
// ----------------------------------------------------------------------------
// qau_lane
// One product lane: four registered 32x32 products, exact signed sum, floor
// shift by the fraction width.
// ----------------------------------------------------------------------------
module qau_lane import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     load,
  input  term_arr_t                terms,
  output logic signed [66-FRAC_BITS:0] sum_shr
);

  logic signed [63:0] prod_r [4];
  logic        [3:0]  neg_r;
  logic signed [66:0] sum;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < 4; j++) begin
        prod_r[j] <= terms[j].x * terms[j].y;
        neg_r[j]  <= terms[j].neg;
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < 4; j++) begin
      if (neg_r[j]) sum = sum - 67'(prod_r[j]);
      else          sum = sum + 67'(prod_r[j]);
    end
    sum_shr = (67-FRAC_BITS)'(sum >>> FRAC_BITS);
  end

endmodule

/* src/qau_div.sv */
// ----------------------------------------------------------------------------
// qau_div
// Restoring divider, one quotient bit per cycle, signed result with clamp.
// ----------------------------------------------------------------------------
module qau_div import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [31+FRAC_BITS:0]   num_mag,
  input  logic                    neg,
  input  logic [64-FRAC_BITS:0]   den,
  output logic                    done,
  output logic [31:0]             result,
  output logic                    sat
);

  localparam int NUMW = 32 + FRAC_BITS;
  localparam int DW   = 65 - FRAC_BITS;
  localparam int RW   = DW + 1;
  localparam int CW   = $clog2(NUMW + 1);

  logic [NUMW-1:0] num_r, num_nxt;
  logic [NUMW-1:0] q_r, q_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   den_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic            neg_r;
  logic [RW-1:0]   rem_sh;

  always_comb begin
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[RW-2:0], num_r[NUMW-1]};
    if (start) begin
      num_nxt = num_mag;
      q_nxt   = '0;
      rem_nxt = '0;
      cnt_nxt = CW'(NUMW);
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[NUMW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        q_nxt   = {q_r[NUMW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[NUMW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
      neg_r <= neg;
    end
  end

  always_comb begin
    sat    = 1'b0;
    result = neg_r ? (32'd0 - q_r[31:0]) : q_r[31:0];
    if (!neg_r && q_r > NUMW'(32'h7FFF_FFFF)) begin
      sat    = 1'b1;
      result = 32'h7FFF_FFFF;
    end else if (neg_r && q_r > NUMW'(32'h8000_0000)) begin
      sat    = 1'b1;
      result = 32'h8000_0000;
    end
  end

  assign done = done_r;

endmodule

/* src/qau_merge.sv */
// ----------------------------------------------------------------------------
// qau_merge
// Output stage: picks the lane or divider results per action, clamps, flags.
// ----------------------------------------------------------------------------
module qau_merge import qau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld,
  input  in_t                         item,
  input  logic signed [66-FRAC_BITS:0] lane_sum [4],
  input  logic                        n_zero,
  input  div_stat_t                   dstat,
  input  logic [3:0][31:0]            dres,
  output logic                        out_valid,
  output out_t                        out_item
);

  logic        valid_r, valid_nxt;
  out_t        res_r, res_nxt;
  logic [3:0][31:0] av, bv, rv;
  logic [3:0]  sv;

  always_comb begin
    av = {item.a_z, item.a_y, item.a_x, item.a_w};
    bv = {item.b_z, item.b_y, item.b_x, item.b_w};
    rv = '0;
    sv = '0;
    valid_nxt = 1'b0;
    res_nxt   = '0;
    if (dstat.done) begin
      valid_nxt = 1'b1;
      rv        = dres;
      sv        = dstat.sat;
    end else if (vld) begin
      valid_nxt = 1'b1;
      for (int k = 0; k < 4; k++) begin
        case (item.action)
          ACT_ADD: {sv[k], rv[k]} = sat32(68'($signed(av[k])) + 68'($signed(bv[k])));
          ACT_SUB: {sv[k], rv[k]} = sat32(68'($signed(av[k])) - 68'($signed(bv[k])));
          ACT_CNJ: begin
            if (k == 0) rv[k] = av[k];
            else {sv[k], rv[k]} = sat32(68'sd0 - 68'($signed(av[k])));
          end
          ACT_SCL, ACT_MUL: {sv[k], rv[k]} = sat32(68'(lane_sum[k]));
          ACT_NRM: begin
            if (k == 0) {sv[k], rv[k]} = sat32(68'(lane_sum[k]));
          end
          ACT_INV: begin
            // nonzero norm goes through the divider instead
            valid_nxt = n_zero;
          end
          default: ;
        endcase
      end
      res_nxt.divide_by_zero = (item.action == ACT_INV) && n_zero;
    end
    res_nxt.r_w       = rv[0];
    res_nxt.r_x       = rv[1];
    res_nxt.r_y       = rv[2];
    res_nxt.r_z       = rv[3];
    res_nxt.saturated = |sv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = res_r;

endmodule
